// File: rtl/dlr_pkg.sv
`default_nettype none

package dlr_pkg;

	localparam int MAX_CHANNELS    = 8;
	localparam int SAMPLE_BITS     = 16;
	localparam int PHASE_FRAC_BITS = 16;
	localparam int PHASE_BITS      = 24;
	localparam int STEP_BITS       = 21;
	localparam int COUNT_BITS      = 4;
	localparam int INDEX_BITS      = 3;
	localparam int SUM_BITS        = 19;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int RECIP_SHIFT     = 24;
	localparam int RECIP_BITS      = RECIP_SHIFT + 1;
	localparam int DIFF_BITS       = SAMPLE_BITS + 1;
	localparam int PROD_BITS       = 2 * DIFF_BITS;

	localparam int QUEUE_DEPTH      = 2;
	localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;
	localparam logic [PHASE_BITS:0]   SUM_ONE   = (PHASE_BITS + 1)'(1) << PHASE_FRAC_BITS;
	localparam logic [PHASE_BITS:0]   SUM_TWO   = (PHASE_BITS + 1)'(2) << PHASE_FRAC_BITS;
	localparam logic [STEP_BITS-1:0]  MIN_STEP  = STEP_BITS'(1) << (PHASE_FRAC_BITS - 2);
	localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_CHANNELS);

	localparam logic [QUEUE_PTR_BITS-1:0]   QUEUE_LAST_SLOT  = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_COUNT_BITS-1:0] QUEUE_FULL_COUNT = QUEUE_COUNT_BITS'(QUEUE_DEPTH);

	localparam logic [COUNT_BITS-1:0] RESET_CHANNEL_COUNT = COUNT_BITS'(1);
	localparam logic [STEP_BITS-1:0]  RESET_PHASE_STEP    = STEP_BITS'(65536);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CHANNEL_COUNT = 1'b0,
		REG_PHASE_STEP    = 1'b1
	} cfg_reg_t;

	// One unit of work for the back end: a finished frame sum and/or end of stream.
	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum;
		logic                       frame_done;
		logic                       last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [COUNT_BITS-1:0] clamp_chans(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS-1:0] r;
		r = c;
		if (c == '0) begin
			r = COUNT_BITS'(1);
		end else if (c > MAX_COUNT) begin
			r = MAX_COUNT;
		end
		return r;
	endfunction

	function automatic logic [STEP_BITS-1:0] clamp_step(input logic [STEP_BITS-1:0] s);
		return (s < MIN_STEP) ? MIN_STEP : s;
	endfunction

	// floor(2^24 / c); the quotient it gives is exact or one low.
	function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] c);
		logic [RECIP_BITS-1:0] r;
		unique case (c)
			4'd2:    r = RECIP_BITS'(8388608);
			4'd3:    r = RECIP_BITS'(5592405);
			4'd4:    r = RECIP_BITS'(4194304);
			4'd5:    r = RECIP_BITS'(3355443);
			4'd6:    r = RECIP_BITS'(2796202);
			4'd7:    r = RECIP_BITS'(2396745);
			4'd8:    r = RECIP_BITS'(2097152);
			default: r = RECIP_BITS'(16777216);
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/dlr_front.sv
`default_nettype none

module dlr_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  signed [dlr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire                                  stream_last,
	input  wire  [dlr_pkg::COUNT_BITS-1:0]       chans,
	input  dlr_pkg::q_status_t                   q_status,
	output logic                                 push,
	output dlr_pkg::job_t                        job
);
	import dlr_pkg::*;

	logic [INDEX_BITS-1:0]      channel_index_q;
	logic signed [SUM_BITS-1:0] frame_sum_q;
	logic signed [SUM_BITS-1:0] sum_next;
	logic [COUNT_BITS-1:0]      index_next;
	logic                       frame_done;
	logic                       accept;

	assign in_ready   = !q_status.full;
	assign accept     = in_valid && in_ready;
	assign sum_next   = frame_sum_q + SUM_BITS'(sample_in);
	assign index_next = COUNT_BITS'(channel_index_q) + COUNT_BITS'(1);
	assign frame_done = index_next >= chans;

	// Items that neither close a frame nor end the stream only update the sum.
	assign push           = accept && (frame_done || stream_last);
	assign job.sum        = sum_next;
	assign job.frame_done = frame_done;
	assign job.last       = stream_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_index_q <= '0;
			frame_sum_q     <= '0;
		end else if (accept) begin
			if (frame_done || stream_last) begin
				channel_index_q <= '0;
				frame_sum_q     <= '0;
			end else begin
				channel_index_q <= index_next[INDEX_BITS-1:0];
				frame_sum_q     <= sum_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/dlr_queue.sv
`default_nettype none

module dlr_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  dlr_pkg::job_t      push_job,
	input  wire                pop,
	output dlr_pkg::job_t      head_job,
	output dlr_pkg::q_status_t status
);
	import dlr_pkg::*;

	job_t                        entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0]   rd_ptr_q;
	logic [QUEUE_COUNT_BITS-1:0] count_q;

	assign head_job     = entry_q[rd_ptr_q];
	assign status.full  = count_q == QUEUE_FULL_COUNT;
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_LAST_SLOT) ? '0 : wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_LAST_SLOT) ? '0 : rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_COUNT_BITS'(1);
				2'b01:   count_q <= count_q - QUEUE_COUNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/dlr_back.sv
`default_nettype none

module dlr_back (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire  [dlr_pkg::COUNT_BITS-1:0]        chans,
	input  wire  [dlr_pkg::STEP_BITS-1:0]         step,
	input  dlr_pkg::job_t                         head_job,
	input  dlr_pkg::q_status_t                    q_status,
	output logic                                  pop,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic signed [dlr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                  run_last,
	output logic                                  stream_end
);
	import dlr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CORR,
		ST_INTERP,
		ST_MUL,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	state_t                        state_q;
	job_t                          job_q;
	logic [SUM_BITS-1:0]           mag_q;
	logic [SUM_BITS+RECIP_BITS-1:0] qprod_q;
	logic signed [SAMPLE_BITS-1:0] mono_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          have_prev_q;
	logic [PHASE_BITS-1:0]         phase_q;
	logic signed [PROD_BITS-1:0]   mprod_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          run_last_q;
	logic                          stream_end_q;

	logic                          slot_free;
	logic                          emit;
	logic [PHASE_BITS:0]           phase_sum;
	logic                          below_one;
	logic                          interp_more;
	logic                          flush_more;
	logic [SUM_BITS-1:0]           mag;
	logic [SUM_BITS-1:0]           q0;
	logic [SUM_BITS+COUNT_BITS-1:0] q0_times_c;
	logic [SUM_BITS+COUNT_BITS-1:0] rem;
	logic [SUM_BITS-1:0]           quot;
	logic [SUM_BITS-1:0]           mono_wide;
	logic signed [DIFF_BITS-1:0]   diff;
	logic [PROD_BITS-PHASE_FRAC_BITS-1:0] interp_wide;

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign run_last   = run_last_q;
	assign stream_end = stream_end_q;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = slot_free && ((state_q == ST_EMIT)
		|| ((state_q == ST_FLUSH) && have_prev_q && below_one));
	assign pop       = (state_q == ST_IDLE) && !q_status.empty;
	assign phase_sum = {1'b0, phase_q} + (PHASE_BITS + 1)'(step);
	assign below_one = phase_q < PHASE_ONE;

	// Another result follows if interpolation continues, or if the stream ends
	// and the flush will still find a position below the last sample.
	assign interp_more = (phase_sum < SUM_ONE) || (job_q.last && (phase_sum < SUM_TWO));
	assign flush_more  = phase_sum < SUM_ONE;

	// Frame division: reciprocal multiply, then one correction step.
	assign mag        = job_q.sum[SUM_BITS-1] ? SUM_BITS'(-job_q.sum) : SUM_BITS'(job_q.sum);
	assign q0         = qprod_q[RECIP_SHIFT +: SUM_BITS];
	assign q0_times_c = q0 * chans;
	assign rem        = (SUM_BITS + COUNT_BITS)'(mag_q) - q0_times_c;
	assign quot       = (rem >= (SUM_BITS + COUNT_BITS)'(chans)) ? q0 + SUM_BITS'(1) : q0;
	assign mono_wide  = job_q.sum[SUM_BITS-1] ? SUM_BITS'(-quot) : quot;

	assign diff        = DIFF_BITS'(mono_q) - DIFF_BITS'(prev_q);
	assign interp_wide = (PROD_BITS - PHASE_FRAC_BITS)'(prev_q)
		+ mprod_q[PROD_BITS-1:PHASE_FRAC_BITS];

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
		if (state_q == ST_DIV) begin
			mag_q   <= mag;
			qprod_q <= mag * recip(chans);
		end
		if (state_q == ST_CORR) begin
			mono_q <= mono_wide[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_MUL) begin
			mprod_q <= diff * $signed({1'b0, phase_q[PHASE_FRAC_BITS-1:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_q       <= '0;
			have_prev_q  <= 1'b0;
			phase_q      <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			run_last_q   <= 1'b0;
			stream_end_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= head_job.frame_done ? ST_DIV : ST_FLUSH;
					end
				end
				ST_DIV: begin
					state_q <= ST_CORR;
				end
				ST_CORR: begin
					if (have_prev_q) begin
						state_q <= ST_INTERP;
					end else begin
						// The first sample of a stream only sets the start point.
						have_prev_q <= 1'b1;
						phase_q     <= '0;
						prev_q      <= mono_wide[SAMPLE_BITS-1:0];
						state_q     <= job_q.last ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_INTERP: begin
					if (below_one) begin
						state_q <= ST_MUL;
					end else begin
						phase_q <= phase_q - PHASE_ONE;
						prev_q  <= mono_q;
						state_q <= job_q.last ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						sample_out_q <= interp_wide[SAMPLE_BITS-1:0];
						run_last_q   <= !interp_more;
						stream_end_q <= job_q.last && !interp_more;
						phase_q      <= phase_sum[PHASE_BITS-1:0];
						state_q      <= ST_INTERP;
					end
				end
				ST_FLUSH: begin
					if (have_prev_q && below_one) begin
						if (slot_free) begin
							out_valid_q  <= 1'b1;
							sample_out_q <= prev_q;
							run_last_q   <= !flush_more;
							stream_end_q <= !flush_more;
							phase_q      <= phase_sum[PHASE_BITS-1:0];
						end
					end else begin
						have_prev_q <= 1'b0;
						phase_q     <= '0;
						prev_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/downmix_linear_resampler_unit.sv
`default_nettype none

// Downmixing linear-interpolation resampler. Interleaved channel samples enter
// one item per cycle while the two-entry job queue is not full; each completed
// frame (or end of stream) becomes one job for the back end. The back end takes
// the job, divides the frame sum by the channel count (reciprocal multiply and
// correction), then for each interpolated result runs a phase check, a multiply
// and an output step, and closes with a phase check that takes the next sample.
// At stream end the flush repeats the last sample while the phase stays below
// one, then clears the state. At the smallest phase step a frame produces up to
// four results. Results leave through an output register, so the back end keeps
// working while a result waits, until its next result is ready to leave.
// Configuration takes effect immediately and must be written only while idle.
module downmix_linear_resampler_unit (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [dlr_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire  [dlr_pkg::STEP_BITS-1:0]          cfg_data,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  signed [dlr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  wire                                    stream_last,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [dlr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic                                   run_last,
	output logic                                   stream_end
);
	import dlr_pkg::*;

	logic [COUNT_BITS-1:0] channel_count_q;
	logic [STEP_BITS-1:0]  phase_step_q;
	logic [COUNT_BITS-1:0] chans;
	logic [STEP_BITS-1:0]  step;
	logic                  q_push;
	logic                  q_pop;
	job_t                  push_job;
	job_t                  head_job;
	q_status_t             q_status;

	assign cfg_ready = 1'b1;
	assign chans     = clamp_chans(channel_count_q);
	assign step      = clamp_step(phase_step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RESET_CHANNEL_COUNT;
			phase_step_q    <= RESET_PHASE_STEP;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_CHANNEL_COUNT) begin
				channel_count_q <= cfg_data[COUNT_BITS-1:0];
			end else if (cfg_index == REG_PHASE_STEP) begin
				phase_step_q <= cfg_data;
			end
		end
	end

	dlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.stream_last(stream_last),
		.chans      (chans),
		.q_status   (q_status),
		.push       (q_push),
		.job        (push_job)
	);

	dlr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(push_job),
		.pop     (q_pop),
		.head_job(head_job),
		.status  (q_status)
	);

	dlr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.chans     (chans),
		.step      (step),
		.head_job  (head_job),
		.q_status  (q_status),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.run_last  (run_last),
		.stream_end(stream_end)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("job popped from an empty queue");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last)
		else $error("stream end result not marked as last of its item");
`endif

endmodule

`default_nettype wire
